>>> hdl/mlrq_pkg.sv
package mlrq_pkg;

  localparam int NUM_QUEUES_DEF  = 5;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int OP_W  = 2;
  localparam int QI_W  = 3;
  localparam int ID_W  = 6;
  localparam int ST_W  = 3;
  localparam int LEN_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      popped_id;
    logic [LEN_W-1:0]     queue_length;
  } result_t;

endpackage

>>> hdl/mlrq_ram.sv
module mlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mlrq_ctrl.sv
module mlrq_ctrl
  import mlrq_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int AW         = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic [OP_W-1:0] req_type,
  input  logic [QI_W-1:0] queue_index,
  input  logic [ID_W-1:0] proc_id,
  output logic            res_valid,
  input  logic            res_ready,
  output result_t         res,
  output logic            mem_we,
  output logic [AW-1:0]   mem_addr,
  output logic [ID_W-1:0] mem_wdata,
  input  logic [ID_W-1:0] mem_rdata
);

  localparam int DW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LW  = (CW > LEN_W) ? CW : LEN_W;

  state_t state, state_next;

  logic [DW-1:0] heads  [NUM_QUEUES];
  logic [CW-1:0] counts [NUM_QUEUES];

  logic [QI_W-1:0] q_r;
  logic [ID_W-1:0] id_r;
  logic [CW-1:0]   n_r;
  logic [DW-1:0]   idx;
  status_t         res_status;
  logic [ID_W-1:0] res_pop;
  logic [CW-1:0]   res_cnt;

  logic [QI_W-1:0] q_sel;
  logic [QIW-1:0]  qi;
  logic [DW-1:0]   head_sel;
  logic [CW-1:0]   cnt_sel;
  logic            bad;
  op_t             op_in;
  logic            full;
  logic            hit;
  logic [DW-1:0]   n_last;
  logic [DW-1:0]   off;
  logic [DW:0]     sum;
  logic [DW-1:0]   ring;
  logic [DW:0]     head_sum;
  logic [DW-1:0]   head_inc;
  logic [LW-1:0]   res_cnt_ext;

  assign q_sel    = (state == S_IDLE) ? queue_index : q_r;
  assign qi       = q_sel[QIW-1:0];
  assign head_sel = heads[qi];
  assign cnt_sel  = counts[qi];
  assign bad      = ({1'b0, queue_index} >= (QI_W+1)'(NUM_QUEUES));
  assign op_in    = op_t'(req_type);
  assign full     = (cnt_sel == CW'(QUEUE_DEPTH));
  assign hit      = (mem_rdata == id_r);
  assign n_last   = DW'(n_r - 1'b1);

  // physical slot: queue base plus ring position from the head
  always_comb begin
    unique case (state)
      S_IDLE:     off = (op_in == OP_PUSH) ? DW'(cnt_sel) : '0;
      S_SHIFT_WR: off = idx - 1'b1;
      default:    off = idx;
    endcase
  end

  assign sum      = {1'b0, head_sel} + {1'b0, off};
  assign ring     = (sum >= (DW+1)'(QUEUE_DEPTH)) ? DW'(sum - (DW+1)'(QUEUE_DEPTH)) : sum[DW-1:0];
  assign mem_addr = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(ring);

  assign head_sum = {1'b0, head_sel} + 1'b1;
  assign head_inc = (head_sum >= (DW+1)'(QUEUE_DEPTH)) ? '0 : head_sum[DW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (bad) begin
            state_next = S_DONE;
          end else begin
            unique case (op_in)
              OP_POP:    state_next = (cnt_sel == '0) ? S_DONE : S_POP_WAIT;
              OP_REMOVE: state_next = (cnt_sel == '0) ? S_DONE : S_SCAN_RD;
              default:   state_next = S_DONE;
            endcase
          end
        end
      end
      S_POP_WAIT: state_next = S_DONE;
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit) begin
          state_next = (idx == n_last) ? S_DONE : S_SHIFT_RD;
        end else begin
          state_next = (idx == '0) ? S_DONE : S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (idx == n_last) ? S_DONE : S_SHIFT_RD;
      S_DONE:     state_next = res_ready ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = proc_id;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        mem_we    = req_valid && !bad && (op_in == OP_PUSH) && !full;
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            q_r        <= queue_index;
            id_r       <= proc_id;
            n_r        <= cnt_sel;
            res_pop    <= '0;
            res_status <= ST_OK;
            res_cnt    <= cnt_sel;
            if (bad) begin
              res_status <= ST_BAD_INDEX;
              res_cnt    <= '0;
            end else begin
              unique case (op_in)
                OP_PUSH: begin
                  if (full) begin
                    res_status <= ST_FULL;
                  end else begin
                    counts[qi] <= cnt_sel + 1'b1;
                    res_cnt    <= cnt_sel + 1'b1;
                  end
                end
                OP_POP: begin
                  if (cnt_sel == '0) res_status <= ST_EMPTY;
                end
                OP_REMOVE: begin
                  if (cnt_sel == '0) res_status <= ST_NOT_FOUND;
                  idx <= DW'(cnt_sel - 1'b1);
                end
                default: ;
              endcase
            end
          end
        end
        S_POP_WAIT: begin
          res_pop    <= mem_rdata;
          heads[qi]  <= head_inc;
          counts[qi] <= n_r - 1'b1;
          res_cnt    <= n_r - 1'b1;
        end
        S_SCAN_CMP: begin
          if (hit) begin
            counts[qi] <= n_r - 1'b1;
            res_cnt    <= n_r - 1'b1;
            if (idx != n_last) idx <= idx + 1'b1;
          end else if (idx == '0) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_SHIFT_WR: begin
          if (idx != n_last) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res_cnt_ext      = LW'(res_cnt);
  assign res.status       = res_status;
  assign res.popped_id    = res_pop;
  assign res.queue_length = res_cnt_ext[LEN_W-1:0];

  a_shift_not_head: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT_WR |-> idx != '0)
    else $error("gap close would write before the head");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_RD || state == S_POP_WAIT) |-> n_r != '0)
    else $error("memory walk on an empty queue");

  a_no_write_on_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_WAIT || state == S_SCAN_CMP || state == S_SCAN_RD) |-> !mem_we)
    else $error("write during a read-only phase");

  a_bad_len_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_BAD_INDEX |-> res.queue_length == '0 && res.popped_id == '0)
    else $error("bad index result carries data");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != S_IDLE)
    else $error("transfer accepted without starting work");

endmodule

>>> hdl/multilevel_ready_queue_set.sv
// Steps to a result: push, bad index, unused type, full or empty go straight to S_DONE;
//   pop goes through S_POP_WAIT; remove scans from the back (S_SCAN_RD, S_SCAN_CMP per entry)
//   and then closes the gap (S_SHIFT_RD, S_SHIFT_WR per entry behind the hit).
// The controller takes one request at a time and walks the entry RAM through a single port.
// Reset (rst, sync): clears queue counts, head pointers and the result valid;
//   the entry RAM is not cleared.
module multilevel_ready_queue_set
  import mlrq_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [OP_W-1:0]  req_type,
  input  logic [QI_W-1:0]  queue_index,
  input  logic [ID_W-1:0]  proc_id,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic [ST_W-1:0]  status,
  output logic [ID_W-1:0]  popped_id,
  output logic [LEN_W-1:0] queue_length
);

  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [ID_W-1:0] mem_wdata;
  logic [ID_W-1:0] mem_rdata;
  logic            res_valid;
  logic            res_ready;
  result_t         res;
  result_t         rsp_q;

  mlrq_ram #(
    .WIDTH (ID_W),
    .DEPTH (MEM_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  mlrq_ctrl #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .queue_index (queue_index),
    .proc_id     (proc_id),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  // result register: holds a finished result while the controller takes the next request
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      rsp_q <= res;
    end
  end

  assign status       = rsp_q.status;
  assign popped_id    = rsp_q.popped_id;
  assign queue_length = rsp_q.queue_length;

endmodule
